// ===== src/olm_pkg.sv =====
// shared types and constants for the order latency monitor
// no dependencies

package olm_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int ID_W          = 32;
    localparam int TIME_W        = 32;
    localparam int SUM_W         = 48;
    localparam int COUNT_W       = 32;

    typedef enum logic [1:0] {
        KIND_IGNORED   = 2'd0,
        KIND_OPENED    = 2'd1,
        KIND_COMPLETED = 2'd2,
        KIND_FULL      = 2'd3
    } kind_t;

    typedef struct packed {
        logic              lookup;
        logic              open_en;
        logic              close_en;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] start_time;
    } cell_ctrl_t;

    typedef struct packed {
        logic [TIME_W-1:0]  max_lat;
        logic [TIME_W-1:0]  min_lat;
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
    } stats_t;

endpackage

// ===== src/olm_cell.sv =====
// one entry of the outstanding order table: id compare, free grant, chained hit data
// depends on olm_pkg

module olm_cell
    import olm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cell_ctrl_t        ctrl,
    input  logic              grant_in,
    input  logic              hit_chain_in,
    input  logic [TIME_W-1:0] start_chain_in,
    output logic              valid_out,
    output logic              hit_chain_out,
    output logic [TIME_W-1:0] start_chain_out
);

    logic              valid_reg;
    logic              hit_reg;
    logic              grant_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] start_hit_reg;
    logic              hit_next;

    assign hit_next = valid_reg && (id_reg == ctrl.id);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
            grant_reg <= 1'b0;
        end else begin
            if (ctrl.lookup) begin
                hit_reg   <= hit_next;
                grant_reg <= grant_in;
            end
            if (ctrl.close_en && hit_reg) begin
                valid_reg <= 1'b0;
            end else if (ctrl.open_en && grant_reg) begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.open_en && grant_reg) begin
            id_reg    <= ctrl.id;
            start_reg <= ctrl.start_time;
        end
        if (ctrl.lookup) begin
            start_hit_reg <= hit_next ? start_reg : '0;
        end
    end

    assign valid_out       = valid_reg;
    assign hit_chain_out   = hit_chain_in | hit_reg;
    assign start_chain_out = start_chain_in | start_hit_reg;

endmodule

// ===== src/olm_stats.sv =====
// running latency statistics: max, min, saturating sum and count
// depends on olm_pkg

module olm_stats
    import olm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              commit,
    input  logic              complete,
    input  logic [TIME_W-1:0] lat,
    output stats_t            stats_next
);

    stats_t           stats_reg;
    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] sum_sat;
    logic [COUNT_W-1:0] count_sat;

    assign sum_wide  = {1'b0, stats_reg.sum} + {{(SUM_W + 1 - TIME_W){1'b0}}, lat};
    assign sum_sat   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    assign count_sat = (stats_reg.count == {COUNT_W{1'b1}}) ? stats_reg.count
                                                           : stats_reg.count + 1'b1;

    always_comb begin
        stats_next = stats_reg;
        if (complete) begin
            if (lat > stats_reg.max_lat) begin
                stats_next.max_lat = lat;
            end
            if (lat < stats_reg.min_lat) begin
                stats_next.min_lat = lat;
            end
            stats_next.sum   = sum_sat;
            stats_next.count = count_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stats_reg.max_lat <= '0;
            stats_reg.min_lat <= {TIME_W{1'b1}};
            stats_reg.sum     <= '0;
            stats_reg.count   <= '0;
        end else if (commit) begin
            stats_reg <= stats_next;
        end
    end

endmodule

// ===== src/order_latency_monitor_unit.sv =====
// Order latency monitor. Each beat on the s_ side is an event (order id, Q16.16 day
// timestamp, machine flag); each produces one beat on the m_ side with the event kind,
// the latency of a completed order and the running max, min, saturating sum and count.
// Each item passes a lookup state, in which every table cell compares the id in parallel
// and the lowest free cell is granted, then an update state that updates the table and
// the statistics and loads the output register. A new event is taken in the update
// state, which waits while a result beat is stalled on m_ready. The
// table holds TABLE_ENTRIES outstanding orders; a new id with no free entry is reported
// as table full and dropped. No clearing pass is needed after reset.
// depends on olm_pkg, olm_cell, olm_stats

module order_latency_monitor_unit
    import olm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_from_machine,
    input  logic signed [ID_W-1:0] s_order_id,
    input  logic [TIME_W-1:0]    s_timestamp,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_event_kind,
    output logic [TIME_W-1:0]    m_latency,
    output logic [TIME_W-1:0]    m_max_latency,
    output logic [TIME_W-1:0]    m_min_latency,
    output logic [SUM_W-1:0]     m_latency_sum,
    output logic [COUNT_W-1:0]   m_completed_count
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPD
    } state_t;

    state_t            state_reg, state_next;
    logic              machine_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] time_reg;
    logic              free_any_reg;

    logic              m_valid_reg;
    kind_t             kind_reg;
    logic [TIME_W-1:0] latency_reg;
    stats_t            stats_out_reg;

    logic                     accept;
    logic                     upd_go;
    kind_t                    kind_next;
    logic [TIME_W-1:0]        lat_next;
    logic [TIME_W-1:0]        hit_start;
    logic                     hit_any;
    logic [TABLE_ENTRIES-1:0] valid_vec;
    logic [TABLE_ENTRIES-1:0] free_vec;
    logic [TABLE_ENTRIES-1:0] grant_vec;
    logic [TABLE_ENTRIES:0]   hit_chain;
    logic [TIME_W-1:0]        start_chain [TABLE_ENTRIES+1];
    cell_ctrl_t               ctrl;
    stats_t                   stats_next;

    assign upd_go  = (state_reg == ST_UPD) && (!m_valid_reg || m_ready);
    assign s_ready = (state_reg == ST_IDLE) || upd_go;
    assign accept  = s_valid && s_ready;

    // lowest free entry as one-hot
    assign free_vec  = ~valid_vec;
    assign grant_vec = free_vec & (~free_vec + 1'b1);

    assign hit_chain[0]   = 1'b0;
    assign start_chain[0] = '0;
    assign hit_any        = hit_chain[TABLE_ENTRIES];
    assign hit_start      = start_chain[TABLE_ENTRIES];

    always_comb begin
        if (machine_reg) begin
            kind_next = KIND_IGNORED;
        end else if (hit_any) begin
            kind_next = KIND_COMPLETED;
        end else if (free_any_reg) begin
            kind_next = KIND_OPENED;
        end else begin
            kind_next = KIND_FULL;
        end
    end

    assign lat_next = (kind_next == KIND_COMPLETED && time_reg >= hit_start)
                    ? time_reg - hit_start : '0;

    assign ctrl.lookup     = (state_reg == ST_LOOK);
    assign ctrl.open_en    = upd_go && (kind_next == KIND_OPENED);
    assign ctrl.close_en   = upd_go && (kind_next == KIND_COMPLETED);
    assign ctrl.id         = id_reg;
    assign ctrl.start_time = time_reg;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
            olm_cell u_cell (
                .aclk            (aclk),
                .aresetn         (aresetn),
                .ctrl            (ctrl),
                .grant_in        (grant_vec[gi]),
                .hit_chain_in    (hit_chain[gi]),
                .start_chain_in  (start_chain[gi]),
                .valid_out       (valid_vec[gi]),
                .hit_chain_out   (hit_chain[gi+1]),
                .start_chain_out (start_chain[gi+1])
            );
        end
    endgenerate

    olm_stats u_stats (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .commit     (upd_go),
        .complete   (kind_next == KIND_COMPLETED),
        .lat        (lat_next),
        .stats_next (stats_next)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (upd_go) begin
                    state_next = accept ? ST_LOOK : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (upd_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            machine_reg <= s_from_machine;
            id_reg      <= $unsigned(s_order_id);
            time_reg    <= s_timestamp;
        end
        if (state_reg == ST_LOOK) begin
            free_any_reg <= |free_vec;
        end
        if (upd_go) begin
            kind_reg      <= kind_next;
            latency_reg   <= lat_next;
            stats_out_reg <= stats_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_event_kind      = kind_reg;
    assign m_latency         = latency_reg;
    assign m_max_latency     = stats_out_reg.max_lat;
    assign m_min_latency     = stats_out_reg.min_lat;
    assign m_latency_sum     = stats_out_reg.sum;
    assign m_completed_count = stats_out_reg.count;

endmodule

// ===== src/olm_checker.sv =====
// port-level checks for order_latency_monitor_unit, attached by bind
// depends on olm_pkg and order_latency_monitor_unit

module olm_checker
    import olm_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_event_kind,
    input logic [TIME_W-1:0]  m_latency,
    input logic [TIME_W-1:0]  m_max_latency,
    input logic [TIME_W-1:0]  m_min_latency,
    input logic [SUM_W-1:0]   m_latency_sum,
    input logic [COUNT_W-1:0] m_completed_count
);

    // stalled beat holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_kind) && $stable(m_latency))
        else $error("result beat changed while stalled");

    // one event in flight: lookup cycle follows every accepted beat
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken during lookup");

    a_lat_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind != KIND_COMPLETED |-> m_latency == '0)
        else $error("latency nonzero for non-completed event");

    a_completed_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind == KIND_COMPLETED |->
            m_max_latency >= m_latency && m_min_latency <= m_latency
            && m_completed_count != '0)
        else $error("statistics inconsistent with completed latency");

    a_sum_ge_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_latency_sum >= {{(SUM_W - TIME_W){1'b0}}, m_max_latency})
        else $error("latency sum below max latency");

endmodule

bind order_latency_monitor_unit olm_checker u_olm_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_event_kind      (m_event_kind),
    .m_latency         (m_latency),
    .m_max_latency     (m_max_latency),
    .m_min_latency     (m_min_latency),
    .m_latency_sum     (m_latency_sum),
    .m_completed_count (m_completed_count)
);

// ===== verif/olm_checker.sv =====
// scoreboard for the order latency monitor: mirrors the table of open orders and the
// running statistics, predicts one result beat per accepted event and compares it
// field by field with the m_ side. depends on olm_pkg

module olm_scoreboard
    import olm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_from_machine,
    input  logic [ID_W-1:0]    s_order_id,
    input  logic [TIME_W-1:0]  s_timestamp,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [1:0]         m_event_kind,
    input  logic [TIME_W-1:0]  m_latency,
    input  logic [TIME_W-1:0]  m_max_latency,
    input  logic [TIME_W-1:0]  m_min_latency,
    input  logic [SUM_W-1:0]   m_latency_sum,
    input  logic [COUNT_W-1:0] m_completed_count,
    output int                 failures,
    output int                 pending_beats
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        kind_t             kind;
        logic [TIME_W-1:0] latency;
        stats_t            stats;
    } monitor_beat_t;

    logic              open_valid [TABLE_ENTRIES];
    logic [ID_W-1:0]   open_id    [TABLE_ENTRIES];
    logic [TIME_W-1:0] open_start [TABLE_ENTRIES];
    stats_t            running;
    monitor_beat_t     expected_beats [$];

    function automatic monitor_beat_t predict_event(input logic machine,
                                                    input logic [ID_W-1:0] id,
                                                    input logic [TIME_W-1:0] now);
        monitor_beat_t  beat;
        int             hit;
        int             free_slot;
        int             i;
        logic [SUM_W:0] wide_sum;
        hit          = -1;
        free_slot    = -1;
        beat.kind    = KIND_IGNORED;
        beat.latency = '0;
        if (!machine) begin
            for (i = 0; i < TABLE_ENTRIES; i++) begin
                if (open_valid[i]) begin
                    if (hit < 0 && open_id[i] == id)
                        hit = i;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (hit >= 0) begin
                beat.kind    = KIND_COMPLETED;
                // time running backwards gives zero latency
                beat.latency = (now >= open_start[hit]) ? now - open_start[hit] : '0;
                open_valid[hit] = 1'b0;
                if (beat.latency > running.max_lat)
                    running.max_lat = beat.latency;
                if (beat.latency < running.min_lat)
                    running.min_lat = beat.latency;
                wide_sum    = {1'b0, running.sum}
                            + {{(SUM_W + 1 - TIME_W){1'b0}}, beat.latency};
                running.sum = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
                if (running.count != '1)
                    running.count = running.count + 1'b1;
            end else if (free_slot >= 0) begin
                beat.kind             = KIND_OPENED;
                open_valid[free_slot] = 1'b1;
                open_id[free_slot]    = id;
                open_start[free_slot] = now;
            end else begin
                beat.kind = KIND_FULL;
            end
        end
        beat.stats = running;
        return beat;
    endfunction

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            failures++;
            if (failures <= 10)
                $display("mismatch on %s: expected %h, got %h", field, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        monitor_beat_t want;
        if (!aresetn) begin
            foreach (open_valid[i])
                open_valid[i] = 1'b0;
            running.max_lat = '0;
            running.min_lat = '1;
            running.sum     = '0;
            running.count   = '0;
            expected_beats.delete();
        end else begin
            if (s_valid && s_ready)
                expected_beats.push_back(predict_event(s_from_machine, s_order_id,
                                                       s_timestamp));
            if (m_valid && m_ready) begin
                if (expected_beats.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("result beat with nothing expected, kind %0d",
                                 m_event_kind);
                end else begin
                    want = expected_beats.pop_front();
                    check_field("event_kind", want.kind, m_event_kind);
                    check_field("latency", want.latency, m_latency);
                    check_field("max_latency", want.stats.max_lat, m_max_latency);
                    check_field("min_latency", want.stats.min_lat, m_min_latency);
                    check_field("latency_sum", want.stats.sum, m_latency_sum);
                    check_field("completed_count", want.stats.count, m_completed_count);
                end
            end
        end
        pending_beats = expected_beats.size();
    end

endmodule

// ===== verif/tb_order_latency_monitor_unit.sv =====
// testbench top for order_latency_monitor_unit: directed events, then random order
// episodes (pools, noise, table fill), with bursty input and patterned output stalls.
// depends on olm_pkg, olm_scoreboard and the block itself

module tb_order_latency_monitor_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import olm_pkg::*;

    typedef enum {
        READY_ALWAYS,
        READY_TOGGLE,
        READY_HALF,
        READY_SPARSE
    } ready_pattern_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_from_machine;
    logic signed [ID_W-1:0] s_order_id;
    logic [TIME_W-1:0]      s_timestamp;
    logic                   m_valid;
    logic                   m_ready;
    logic [1:0]             m_event_kind;
    logic [TIME_W-1:0]      m_latency;
    logic [TIME_W-1:0]      m_max_latency;
    logic [TIME_W-1:0]      m_min_latency;
    logic [SUM_W-1:0]       m_latency_sum;
    logic [COUNT_W-1:0]     m_completed_count;
    int                     failures;
    int                     pending_beats;

    int                sent_count;
    int                burst_left;
    logic [TIME_W-1:0] stamp_clock;
    bit                order_open [logic [ID_W-1:0]];

    order_latency_monitor_unit uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_from_machine    (s_from_machine),
        .s_order_id        (s_order_id),
        .s_timestamp       (s_timestamp),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_event_kind      (m_event_kind),
        .m_latency         (m_latency),
        .m_max_latency     (m_max_latency),
        .m_min_latency     (m_min_latency),
        .m_latency_sum     (m_latency_sum),
        .m_completed_count (m_completed_count)
    );

    olm_scoreboard monitor_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_from_machine    (s_from_machine),
        .s_order_id        (s_order_id),
        .s_timestamp       (s_timestamp),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_event_kind      (m_event_kind),
        .m_latency         (m_latency),
        .m_max_latency     (m_max_latency),
        .m_min_latency     (m_min_latency),
        .m_latency_sum     (m_latency_sum),
        .m_completed_count (m_completed_count),
        .failures          (failures),
        .pending_beats     (pending_beats)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(0, 15))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '1;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] next_stamp();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
            stamp_clock = stamp_clock + $urandom_range(0, 32'h3_0000);
            return stamp_clock;
        end
        if (pick < 18)
            return $urandom;
        return (pick == 18) ? '0 : '1;
    endfunction

    task automatic send_event(input logic machine, input logic [ID_W-1:0] id,
                              input logic [TIME_W-1:0] stamp);
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_from_machine <= machine;
        s_order_id     <= id;
        s_timestamp    <= stamp;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    task automatic send_order(input logic [ID_W-1:0] id);
        order_open[id] = order_open.exists(id) ? !order_open[id] : 1'b1;
        send_event(1'b0, id, next_stamp());
    endtask

    task automatic close_leftovers();
        foreach (order_open[k])
            if (order_open[k])
                send_event(1'b0, k, next_stamp());
        order_open.delete();
    endtask

    task automatic run_pool_episode();
        logic [ID_W-1:0] pool [$];
        int              pool_n;
        int              n;
        pool_n = $urandom_range(1, 40);
        repeat (pool_n) pool.push_back(pick_id());
        n = $urandom_range(pool_n, 3 * pool_n);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0)
                send_event(1'b1, pick_id(), next_stamp());
            else
                send_order(pool[$urandom_range(0, pool_n - 1)]);
        end
        close_leftovers();
    endtask

    // fill every entry, overflow a few ids, then drain in shuffled order
    task automatic run_fill_episode();
        logic [ID_W-1:0] fill_ids [$];
        logic [ID_W-1:0] base;
        logic [ID_W-1:0] stride;
        logic [ID_W-1:0] swap;
        int              extra;
        int              i;
        int              j;
        close_leftovers();
        extra  = $urandom_range(1, 6);
        base   = $urandom;
        stride = $urandom | 32'd1;
        for (i = 0; i < TABLE_ENTRIES + extra; i++) begin
            fill_ids.push_back(base + i * stride);
            send_event(1'b0, fill_ids[i], next_stamp());
        end
        for (i = TABLE_ENTRIES - 1; i > 0; i--) begin
            j           = $urandom_range(0, i);
            swap        = fill_ids[i];
            fill_ids[i] = fill_ids[j];
            fill_ids[j] = swap;
        end
        for (i = 0; i < TABLE_ENTRIES + extra; i++)
            send_event(1'b0, fill_ids[i], next_stamp());
        for (i = TABLE_ENTRIES; i < TABLE_ENTRIES + extra; i++)
            send_event(1'b0, fill_ids[i], next_stamp());
    endtask

    initial begin : receiver
        ready_pattern_t pattern;
        int             stretch;
        bit             hold_done;
        bit             toggle;
        m_ready   = 1'b0;
        pattern   = READY_ALWAYS;
        stretch   = 0;
        hold_done = 1'b0;
        toggle    = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (!hold_done && sent_count >= 60) begin
                // long hold so the block backs up into its input
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (400) @(negedge aclk);
            end else begin
                if (stretch == 0) begin
                    pattern = ready_pattern_t'($urandom_range(0, 3));
                    stretch = $urandom_range(8, 80);
                end
                stretch--;
                toggle = !toggle;
                case (pattern)
                    READY_ALWAYS: m_ready <= 1'b1;
                    READY_TOGGLE: m_ready <= toggle;
                    READY_HALF:   m_ready <= $urandom_range(0, 1);
                    default:      m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        int pick;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_from_machine = 1'b0;
        s_order_id     = '0;
        s_timestamp    = '0;
        burst_left     = 0;
        sent_count     = 0;
        stamp_clock    = $urandom;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: machine events, id extremes, all-ones latency, time backwards, reuse
        send_event(1'b1, 32'h0000_0000, 32'h0000_0000);
        send_event(1'b0, 32'h8000_0000, 32'h0000_0000);
        send_event(1'b1, 32'h8000_0000, 32'hFFFF_FFFF);
        send_event(1'b0, 32'h8000_0000, 32'hFFFF_FFFF);
        send_event(1'b0, 32'h7FFF_FFFF, 32'h0001_0000);
        send_event(1'b0, 32'hFFFF_FFFF, 32'h0002_8000);
        send_event(1'b0, 32'h7FFF_FFFF, 32'h0000_0000);
        send_event(1'b0, 32'hFFFF_FFFF, 32'h0003_0000);
        send_event(1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
        send_event(1'b0, 32'h0000_0001, 32'h5555_5555);
        send_event(1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
        send_event(1'b0, 32'h0000_0000, 32'hAAAA_AAAA);
        send_event(1'b0, 32'h0000_0001, 32'hAAAA_AAAA);
        send_event(1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
        send_event(1'b1, 32'h1234_5678, 32'h8765_4321);

        while (sent_count < 1750) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                run_fill_episode();
            end else if (pick < 3) begin
                // stray events, left open across the next episode
                if (order_open.size() > 20)
                    close_leftovers();
                repeat ($urandom_range(1, 10)) begin
                    if ($urandom_range(0, 1))
                        send_event(1'b1, pick_id(), next_stamp());
                    else
                        send_order(pick_id());
                end
            end else begin
                run_pool_episode();
            end
        end
        close_leftovers();

        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_beats == 0);
        repeat (20) @(posedge aclk);
        if (failures == 0 && pending_beats == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== order_latency_monitor_unit.f =====
src/olm_pkg.sv
src/olm_cell.sv
src/olm_stats.sv
src/order_latency_monitor_unit.sv
src/olm_checker.sv
verif/olm_checker.sv
verif/tb_order_latency_monitor_unit.sv
